FILE: hdl/delay_line_pitch_shifter_defines.svh
// Assertion helpers for the checker of the pitch shifter.
`ifndef DELAY_LINE_PITCH_SHIFTER_DEFINES_SVH
`define DELAY_LINE_PITCH_SHIFTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DLPS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dlps check failed");

// Next-cycle implication, disabled during reset.
`define DLPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dlps check failed");

`endif

FILE: hdl/dlps_pkg.sv
package dlps_pkg;

   localparam int DATA_W       = 24;
   localparam int STEP_W       = 18;
   localparam int MAXD_W       = 12;
   localparam int PHASE_W      = 2;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 18;
   localparam int FRAC_W       = 16;
   localparam int DELAY_W      = 28;
   localparam int WHOLE_W      = DELAY_W - FRAC_W;
   localparam int SUM_W        = DELAY_W + 1;
   localparam int BUFFER_DEPTH = 4096;
   localparam int PIPE_SLOTS   = 5;

   localparam logic [MAXD_W-1:0]  MAX_DELAY_RESET = 12'd2048;
   localparam logic [MAXD_W-1:0]  MAX_DELAY_FLOOR = 12'd3;
   localparam logic [DELAY_W-1:0] MIN_DELAY_FX    = 28'h002_0000;

   // x / 3 == (x * 0xAAAB) >> 17 for any x below 2^16
   localparam logic [15:0]       THIRD_RECIP     = 16'hAAAB;
   localparam int                THIRD_SHIFT     = 17;
   localparam logic [FRAC_W-1:0] FRAC_THIRD      = 16'd21845;
   localparam logic [FRAC_W-1:0] FRAC_TWO_THIRDS = 16'd43690;

   typedef logic signed [DATA_W-1:0] sample_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELAY_STEP  = 2'd0,
      CSR_MAX_DELAY   = 2'd1,
      CSR_START_PHASE = 2'd2
   } csr_idx_type;

   typedef enum logic [PHASE_W-1:0] {
      PHASE_MIN        = 2'd0,
      PHASE_THIRD      = 2'd1,
      PHASE_TWO_THIRDS = 2'd2
   } phase_type;

   typedef struct packed {
      logic              valid;
      logic              wrapped;
      logic              live0;
      logic              live1;
      logic [FRAC_W-1:0] frac;
   } tap_req_type;

endpackage

FILE: hdl/dlps_channels.sv
interface dlps_req_if;
   logic                 valid;
   logic                 ready;
   dlps_pkg::sample_type sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

interface dlps_rsp_if;
   logic                 valid;
   logic                 ready;
   dlps_pkg::sample_type sample_out;
   logic                 sweep_wrapped;
   modport source (output valid, output sample_out, output sweep_wrapped, input ready);
   modport sink (input valid, input sample_out, input sweep_wrapped, output ready);
endinterface

interface dlps_csr_if;
   logic                               valid;
   logic                               ready;
   logic [dlps_pkg::CSR_IDX_W-1:0]     index;
   logic [dlps_pkg::CSR_DATA_W-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/dlps_mem.sv
module dlps_mem #(
   parameter int  DEPTH = dlps_pkg::BUFFER_DEPTH,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  dlps_pkg::sample_type wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr0,
   input  logic [AW-1:0]        rd_addr1,
   output dlps_pkg::sample_type rd_data0_ff,
   output dlps_pkg::sample_type rd_data1_ff
);

   dlps_pkg::sample_type sample_store_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sample_store_ff[wr_addr] <= wr_data;
      end
   end

   // read-before-write: a read at the address being written returns the old entry
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data0_ff <= sample_store_ff[rd_addr0];
         rd_data1_ff <= sample_store_ff[rd_addr1];
      end
   end

endmodule

FILE: hdl/dlps_ctl.sv
module dlps_ctl #(
   parameter int  DEPTH = dlps_pkg::BUFFER_DEPTH,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   dlps_req_if.sink              req,
   dlps_csr_if.sink              csr,
   input  logic                  tap_ready,
   output dlps_pkg::tap_req_type tap_req,
   output logic                  wr_en,
   output logic [AW-1:0]         wr_addr,
   output dlps_pkg::sample_type  wr_data,
   output logic [AW-1:0]         rd_addr0,
   output logic [AW-1:0]         rd_addr1
);

   localparam int EXT_W = (AW > dlps_pkg::WHOLE_W) ? AW : dlps_pkg::WHOLE_W;

   function automatic logic [dlps_pkg::DELAY_W-1:0] start_delay(
      input logic [dlps_pkg::MAXD_W-1:0] max_val,
      input dlps_pkg::phase_type         phase
   );
      logic [dlps_pkg::MAXD_W-1:0]    eff;
      logic [dlps_pkg::MAXD_W:0]      num;
      logic [dlps_pkg::MAXD_W+16:0]   prod;
      logic [dlps_pkg::MAXD_W-1:0]    quo;
      logic [1:0]                     rem;
      logic [dlps_pkg::FRAC_W-1:0]    part;
      logic [dlps_pkg::DELAY_W-1:0]   res;
      eff  = (max_val < dlps_pkg::MAX_DELAY_FLOOR) ? dlps_pkg::MAX_DELAY_FLOOR : max_val;
      num  = (phase == dlps_pkg::PHASE_TWO_THIRDS) ? {eff, 1'b0} : {1'b0, eff};
      prod = num * dlps_pkg::THIRD_RECIP;
      quo  = prod[dlps_pkg::THIRD_SHIFT +: dlps_pkg::MAXD_W];
      rem  = 2'(num - {quo, 1'b0} - {1'b0, quo});
      part = (rem == 2'd1) ? dlps_pkg::FRAC_THIRD :
             (rem == 2'd2) ? dlps_pkg::FRAC_TWO_THIRDS : '0;
      if (phase == dlps_pkg::PHASE_THIRD || phase == dlps_pkg::PHASE_TWO_THIRDS) begin
         res = {quo, part};
      end else begin
         res = dlps_pkg::MIN_DELAY_FX;
      end
      return res;
   endfunction

   logic signed [dlps_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [dlps_pkg::MAXD_W-1:0]         max_ff, max_in;
   dlps_pkg::phase_type                 phase_ff, phase_in;
   logic [dlps_pkg::DELAY_W-1:0]        delay_ff, delay_in;
   logic [AW-1:0]                       wp_ff, wp_in;
   logic                                full_ff, full_in;

   logic                                s1_valid_ff;
   logic [dlps_pkg::WHOLE_W-1:0]        s1_whole_ff;
   logic [dlps_pkg::FRAC_W-1:0]         s1_frac_ff;
   logic                                s1_wrapped_ff;
   logic [AW-1:0]                       s1_wp_ff;
   logic                                s1_full_ff;

   logic                                take1;
   logic                                accept;
   logic                                reload;
   logic [dlps_pkg::MAXD_W-1:0]         eff_max;
   logic [dlps_pkg::DELAY_W-1:0]        max_fx;
   logic signed [dlps_pkg::SUM_W-1:0]   sum;
   logic signed [dlps_pkg::SUM_W-1:0]   min_s;
   logic signed [dlps_pkg::SUM_W-1:0]   max_s;
   logic                                step_pos;
   logic [dlps_pkg::DELAY_W-1:0]        delay_upd;
   logic                                wrapped;
   logic [EXT_W-1:0]                    tap_dist;

   assign take1     = !s1_valid_ff || tap_ready;
   assign req.ready = take1;
   assign accept    = req.valid && take1;
   assign csr.ready = 1'b1;

   assign wr_en   = accept;
   assign wr_addr = wp_ff;
   assign wr_data = req.sample_in;

   // delay update for the incoming request
   assign eff_max  = (max_ff < dlps_pkg::MAX_DELAY_FLOOR) ? dlps_pkg::MAX_DELAY_FLOOR : max_ff;
   assign max_fx   = {eff_max, {dlps_pkg::FRAC_W{1'b0}}};
   assign sum      = $signed({1'b0, delay_ff}) +
                     $signed({{(dlps_pkg::SUM_W - dlps_pkg::STEP_W){step_ff[dlps_pkg::STEP_W-1]}},
                              step_ff});
   assign min_s    = $signed({1'b0, dlps_pkg::MIN_DELAY_FX});
   assign max_s    = $signed({1'b0, max_fx});
   assign step_pos = !step_ff[dlps_pkg::STEP_W-1] && (step_ff != '0);

   always_comb begin
      delay_upd = sum[dlps_pkg::DELAY_W-1:0];
      wrapped   = 1'b0;
      if (!step_pos && sum < min_s) begin
         delay_upd = max_fx;
         wrapped   = 1'b1;
      end else if (step_pos && sum > max_s) begin
         delay_upd = dlps_pkg::MIN_DELAY_FX;
         wrapped   = 1'b1;
      end
   end

   always_comb begin
      step_in  = step_ff;
      max_in   = max_ff;
      phase_in = phase_ff;
      delay_in = delay_ff;
      wp_in    = wp_ff;
      full_in  = full_ff;
      reload   = 1'b0;
      if (accept) begin
         delay_in = delay_upd;
         wp_in    = wp_ff + AW'(1);
         full_in  = full_ff || (wp_ff == '1);
      end
      if (csr.valid) begin
         unique case (dlps_pkg::csr_idx_type'(csr.index))
            dlps_pkg::CSR_DELAY_STEP: begin
               step_in = csr.data[dlps_pkg::STEP_W-1:0];
            end
            dlps_pkg::CSR_MAX_DELAY: begin
               max_in = csr.data[dlps_pkg::MAXD_W-1:0];
               reload = 1'b1;
            end
            dlps_pkg::CSR_START_PHASE: begin
               phase_in = dlps_pkg::phase_type'(csr.data[dlps_pkg::PHASE_W-1:0]);
               reload   = 1'b1;
            end
            default: begin
            end
         endcase
      end
      if (reload) begin
         delay_in = start_delay(max_in, phase_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= '0;
         max_ff      <= dlps_pkg::MAX_DELAY_RESET;
         phase_ff    <= dlps_pkg::PHASE_MIN;
         delay_ff    <= dlps_pkg::MIN_DELAY_FX;
         wp_ff       <= '0;
         full_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         max_ff   <= max_in;
         phase_ff <= phase_in;
         delay_ff <= delay_in;
         wp_ff    <= wp_in;
         full_ff  <= full_in;
         if (take1) begin
            s1_valid_ff <= accept;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take1) begin
         s1_whole_ff   <= delay_upd[dlps_pkg::DELAY_W-1:dlps_pkg::FRAC_W];
         s1_frac_ff    <= delay_upd[dlps_pkg::FRAC_W-1:0];
         s1_wrapped_ff <= wrapped;
         s1_wp_ff      <= wp_in;
         s1_full_ff    <= full_in;
      end
   end

   // taps sit behind the advanced write pointer, modulo the store depth
   assign tap_dist = EXT_W'(s1_wp_ff) - EXT_W'(s1_whole_ff);
   assign rd_addr0 = tap_dist[AW-1:0];
   assign rd_addr1 = rd_addr0 - AW'(1);

   // entries never written read as zero
   assign tap_req.valid   = s1_valid_ff;
   assign tap_req.wrapped = s1_wrapped_ff;
   assign tap_req.live0   = s1_full_ff || (rd_addr0 < s1_wp_ff);
   assign tap_req.live1   = s1_full_ff || (rd_addr1 < s1_wp_ff);
   assign tap_req.frac    = s1_frac_ff;

endmodule

FILE: hdl/dlps_interp.sv
module dlps_interp (
   input  logic                  clock,
   input  logic                  reset,
   input  dlps_pkg::tap_req_type tap_req,
   output logic                  tap_ready,
   input  dlps_pkg::sample_type  rd_data0,
   input  dlps_pkg::sample_type  rd_data1,
   dlps_rsp_if.source            rsp
);

   localparam int DIFF_W = dlps_pkg::DATA_W + 1;
   localparam int PROD_W = DIFF_W + dlps_pkg::FRAC_W + 1;
   localparam int KEEP_W = dlps_pkg::DATA_W + dlps_pkg::FRAC_W;

   dlps_pkg::tap_req_type            s2_ff;

   logic                             s3_valid_ff;
   logic                             s3_wrapped_ff;
   logic [dlps_pkg::FRAC_W-1:0]      s3_frac_ff;
   dlps_pkg::sample_type             s3_base_ff;
   logic signed [DIFF_W-1:0]         s3_diff_ff;

   logic                             s4_valid_ff;
   logic                             s4_wrapped_ff;
   dlps_pkg::sample_type             s4_base_ff;
   logic signed [KEEP_W-1:0]         s4_prod_ff;

   logic                             out_valid_ff;
   logic                             out_wrapped_ff;
   dlps_pkg::sample_type             out_sample_ff;

   logic                             take2, take3, take4, take_out;
   dlps_pkg::sample_type             tap0, tap1;
   logic signed [DIFF_W-1:0]         diff;
   logic signed [PROD_W-1:0]         prod;

   assign take_out  = !out_valid_ff || rsp.ready;
   assign take4     = !s4_valid_ff || take_out;
   assign take3     = !s3_valid_ff || take4;
   assign take2     = !s2_ff.valid || take3;
   assign tap_ready = take2;

   assign tap0 = s2_ff.live0 ? rd_data0 : '0;
   assign tap1 = s2_ff.live1 ? rd_data1 : '0;
   assign diff = $signed({tap1[dlps_pkg::DATA_W-1], tap1}) -
                 $signed({tap0[dlps_pkg::DATA_W-1], tap0});

   // near*(1-g) + far*g == near + g*(far - near); flooring by the shift
   assign prod = s3_diff_ff * $signed({1'b0, s3_frac_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff        <= '0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take2) begin
            s2_ff <= tap_req;
         end
         if (take3) begin
            s3_valid_ff <= s2_ff.valid;
         end
         if (take4) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (take_out) begin
            out_valid_ff <= s4_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take3) begin
         s3_wrapped_ff <= s2_ff.wrapped;
         s3_frac_ff    <= s2_ff.frac;
         s3_base_ff    <= tap0;
         s3_diff_ff    <= diff;
      end
      if (take4) begin
         s4_wrapped_ff <= s3_wrapped_ff;
         s4_base_ff    <= s3_base_ff;
         s4_prod_ff    <= prod[KEEP_W-1:0];
      end
      if (take_out) begin
         out_wrapped_ff <= s4_wrapped_ff;
         out_sample_ff  <= s4_base_ff + s4_prod_ff[dlps_pkg::FRAC_W +: dlps_pkg::DATA_W];
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.sample_out    = out_sample_ff;
   assign rsp.sweep_wrapped = out_wrapped_ff;

endmodule

FILE: hdl/delay_line_pitch_shifter.sv
// Pipeline: an accepted request passes the tap address, store read, difference, product and
//   sum registers before its response is valid; a stalled rsp holds it in place.
// Throughput: one request per cycle while rsp is not stalled; the sample store does one write and two reads a cycle.
// Reset: registers return to step 0, max delay 2048, start phase 0; delay 2.0, write
//   pointer 0. The store is not swept: a fill mark makes never-written entries read zero.
module delay_line_pitch_shifter #(
   parameter int BUFFER_DEPTH = dlps_pkg::BUFFER_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   dlps_req_if.sink    req_ch,
   dlps_rsp_if.source  rsp_ch,
   dlps_csr_if.sink    csr_ch
);

   localparam int AW = $clog2(BUFFER_DEPTH);

   dlps_pkg::tap_req_type tap_req;
   logic                  tap_ready;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   dlps_pkg::sample_type  wr_data;
   logic [AW-1:0]         rd_addr0, rd_addr1;
   dlps_pkg::sample_type  rd_data0, rd_data1;

   dlps_ctl #(.DEPTH(BUFFER_DEPTH)) u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .csr       (csr_ch),
      .tap_ready (tap_ready),
      .tap_req   (tap_req),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr0  (rd_addr0),
      .rd_addr1  (rd_addr1)
   );

   dlps_mem #(.DEPTH(BUFFER_DEPTH)) u_mem (
      .clock       (clock),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (tap_ready),
      .rd_addr0    (rd_addr0),
      .rd_addr1    (rd_addr1),
      .rd_data0_ff (rd_data0),
      .rd_data1_ff (rd_data1)
   );

   dlps_interp u_interp (
      .clock     (clock),
      .reset     (reset),
      .tap_req   (tap_req),
      .tap_ready (tap_ready),
      .rd_data0  (rd_data0),
      .rd_data1  (rd_data1),
      .rsp       (rsp_ch)
   );

endmodule

FILE: hdl/dlps_checker.sv
`include "delay_line_pitch_shifter_defines.svh"

module dlps_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input dlps_pkg::sample_type rsp_sample_out,
   input logic                 rsp_sweep_wrapped
);

   localparam int CNT_W = $clog2(dlps_pkg::PIPE_SLOTS + 1);

   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (req_valid && req_ready) begin
         count_in = count_in + CNT_W'(1);
      end
      if (rsp_valid && rsp_ready) begin
         count_in = count_in - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   `DLPS_ASSERT_IMPL(a_rsp_has_request, clock, reset, rsp_valid, count_ff != '0)
   `DLPS_ASSERT_IMPL(a_in_flight_bound, clock, reset, 1'b1, count_ff <= CNT_W'(dlps_pkg::PIPE_SLOTS))
   `DLPS_ASSERT_IMPL(a_full_follows_rsp, clock, reset, count_ff == CNT_W'(dlps_pkg::PIPE_SLOTS), rsp_valid && (req_ready == rsp_ready))
   `DLPS_ASSERT_IMPL(a_empty_after_reset, clock, reset, $past(reset), req_ready && !rsp_valid)
   `DLPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sample_out) && $stable(rsp_sweep_wrapped))

endmodule

bind delay_line_pitch_shifter dlps_checker u_dlps_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_sample_out    (rsp_ch.sample_out),
   .rsp_sweep_wrapped (rsp_ch.sweep_wrapped)
);
